// File: rtl/lra_pkg.sv
// Shared types, codes and fixed-point helpers for the low-rank adapter engine.
// Used by lra_acc and low_rank_adapter_engine; depends on nothing.
`default_nettype none

package lra_pkg;

  localparam int DEF_MAX_LAYERS  = 4;
  localparam int DEF_MAX_IN_DIM  = 256;
  localparam int DEF_MAX_OUT_DIM = 256;
  localparam int DEF_MAX_RANK    = 16;

  typedef enum logic [2:0] {
    OP_WR_A     = 3'd0,
    OP_WR_B     = 3'd1,
    OP_FWD_X    = 3'd2,
    OP_FWD_OUT  = 3'd3,
    OP_BWD_X    = 3'd4,
    OP_BWD_GOUT = 3'd5,
    OP_BWD_GIN  = 3'd6,
    OP_RD_GRAD  = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LAYER = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  localparam logic [2:0] REG_LAYERS  = 3'd0;
  localparam logic [2:0] REG_IN_DIM  = 3'd1;
  localparam logic [2:0] REG_OUT_DIM = 3'd2;
  localparam logic [2:0] REG_RANK    = 3'd3;
  localparam logic [2:0] REG_SCALE   = 3'd4;

  typedef struct packed {
    logic clr_proj;
    logic clr_bproj;
    logic add_proj;
    logic add_bproj;
  } acc_cmd_t;

  // Q16.16 product realignment; arithmetic shift is a floor.
  function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
    floor16 = v >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sadd64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sadd64 = s[63:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/lra_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
`default_nettype none

module lra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/lra_acc.sv
// Rank projection and back-projection accumulator banks (64-bit, saturating).
// Depends on lra_pkg for acc_cmd_t and the fixed-point helpers.
`default_nettype none

module lra_acc import lra_pkg::*; #(
  parameter int MAX_RANK = DEF_MAX_RANK,
  localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire acc_cmd_t            cmd,
  input  wire logic [RW-1:0]       idx,
  input  wire logic signed [63:0]  addend,
  output logic signed [31:0]       proj_q,
  output logic signed [31:0]       bproj_q
);

  logic signed [63:0] proj_r  [MAX_RANK];
  logic signed [63:0] bproj_r [MAX_RANK];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        proj_r[i]  <= '0;
        bproj_r[i] <= '0;
      end
    end else begin
      if (cmd.clr_proj) begin
        for (int i = 0; i < MAX_RANK; i++) proj_r[i] <= '0;
      end else if (cmd.add_proj) begin
        proj_r[idx] <= sadd64(proj_r[idx], addend);
      end
      if (cmd.clr_bproj) begin
        for (int i = 0; i < MAX_RANK; i++) bproj_r[i] <= '0;
      end else if (cmd.add_bproj) begin
        bproj_r[idx] <= sadd64(bproj_r[idx], addend);
      end
    end
  end

  assign proj_q  = sat32(proj_r[idx]);
  assign bproj_q = sat32(bproj_r[idx]);

endmodule

`default_nettype wire

// File: rtl/low_rank_adapter_engine.sv
// Top level of the low-rank adapter engine: sequencer, multipliers and memories.
// Depends on lra_pkg, lra_ram and lra_acc.
//
// Usage. Items enter on the in_ valid/ready channel, one result item per input
// item leaves on the out_ valid/ready channel. Sizes and scale are set through
// the cfg_ write port, by the user only while the engine is idle; the engine
// itself does not enforce it. Ops 0 and 1 load A and B weights, ops 2 and 3
// run the forward pass, ops 4 to 6 the backward pass, op 7 reads a gradient
// entry. Every item returns a status and a Q16.16 value. Weight writes, errors
// and gradient reads take no rank walk. Each rank entry walks through read,
// multiply and accumulate steps on one shared pair of multipliers, and ops 5
// and 6 add a read-modify-write of the gradient memory. Ops 3 and 6 end with
// a final scale step, which op 6 skips when skip_result is set. One item is in
// flight at a time; the next is taken once the result is in the output register.
// After reset the engine sweeps weight_b and both gradient memories to zero,
// one entry per cycle, with in_ready low. Configuration writes are taken during
// the sweep. When the receiver stalls, the result waits in the output register;
// a new item is still accepted and runs, and it holds in its final step until
// the slot frees.
`default_nettype none

module low_rank_adapter_engine import lra_pkg::*; #(
  parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
  parameter int MAX_IN_DIM  = DEF_MAX_IN_DIM,
  parameter int MAX_OUT_DIM = DEF_MAX_OUT_DIM,
  parameter int MAX_RANK    = DEF_MAX_RANK
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_write_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_operation,
  input  wire logic [1:0]         in_layer,
  input  wire logic [7:0]         in_row_index,
  input  wire logic [7:0]         in_col_index,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_matrix_sel,
  input  wire logic               in_skip_result,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_result_value
);

  localparam int A_SIZE    = MAX_LAYERS * MAX_RANK * MAX_IN_DIM;
  localparam int B_SIZE    = MAX_LAYERS * MAX_OUT_DIM * MAX_RANK;
  localparam int A_AW      = (A_SIZE > 1) ? $clog2(A_SIZE) : 1;
  localparam int B_AW      = (B_SIZE > 1) ? $clog2(B_SIZE) : 1;
  localparam int T_AW      = (MAX_IN_DIM > 1) ? $clog2(MAX_IN_DIM) : 1;
  localparam int CLR_DEPTH = (A_SIZE > B_SIZE) ? A_SIZE : B_SIZE;
  localparam int CLR_AW    = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int RW        = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_GRD  = 10'b0000000100,
    S_RD   = 10'b0000001000,
    S_MUL  = 10'b0000010000,
    S_SCL  = 10'b0000100000,
    S_WB   = 10'b0001000000,
    S_FIN1 = 10'b0010000000,
    S_FIN2 = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  // Flat element index of A[layer][rank][col] and B[layer][row][rank].
  function automatic logic [A_AW-1:0] a_index(input logic [1:0] l, input logic [7:0] rk,
                                               input logic [7:0] c);
    a_index = A_AW'((32'(l) * 32'(MAX_RANK) + 32'(rk)) * 32'(MAX_IN_DIM) + 32'(c));
  endfunction

  function automatic logic [B_AW-1:0] b_index(input logic [1:0] l, input logic [7:0] rw,
                                              input logic [7:0] rk);
    b_index = B_AW'((32'(l) * 32'(MAX_OUT_DIM) + 32'(rw)) * 32'(MAX_RANK) + 32'(rk));
  endfunction

  // Configuration registers.
  logic [2:0]  cfg_layers_r;
  logic [8:0]  cfg_in_dim_r;
  logic [8:0]  cfg_out_dim_r;
  logic [4:0]  cfg_rank_r;
  logic [31:0] cfg_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_layers_r  <= 3'd4;
      cfg_in_dim_r  <= 9'd256;
      cfg_out_dim_r <= 9'd256;
      cfg_rank_r    <= 5'd16;
      cfg_scale_r   <= 32'd65536;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_LAYERS:  cfg_layers_r  <= cfg_data[2:0];
        REG_IN_DIM:  cfg_in_dim_r  <= cfg_data[8:0];
        REG_OUT_DIM: cfg_out_dim_r <= cfg_data[8:0];
        REG_RANK:    cfg_rank_r    <= cfg_data[4:0];
        REG_SCALE:   cfg_scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes: each register is capped at its build-time maximum.
  logic [2:0] nl;
  logic [8:0] ni, no, nr9;
  logic [4:0] nr;
  assign nl  = (32'(cfg_layers_r) < 32'(MAX_LAYERS)) ? cfg_layers_r : 3'(MAX_LAYERS);
  assign ni  = (32'(cfg_in_dim_r) < 32'(MAX_IN_DIM)) ? cfg_in_dim_r : 9'(MAX_IN_DIM);
  assign no  = (32'(cfg_out_dim_r) < 32'(MAX_OUT_DIM)) ? cfg_out_dim_r : 9'(MAX_OUT_DIM);
  assign nr  = (32'(cfg_rank_r) < 32'(MAX_RANK)) ? cfg_rank_r : 5'(MAX_RANK);
  assign nr9 = {4'd0, nr};

  state_t state_r, state_nxt;

  // Latched item.
  op_t                op_r;
  logic [1:0]         layer_r;
  logic [7:0]         row_r, col_r;
  logic signed [31:0] val_r;
  logic               msel_r, skip_r;
  logic [1:0]         status_r;
  logic signed [31:0] res_r;

  logic [RW-1:0]      r_r;
  logic signed [63:0] sum_r, m1_r, m2_r, ms_r;
  logic [CLR_AW-1:0]  clr_cnt_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_result_r;

  // Accept-side decode straight from the ports.
  op_t        in_op;
  logic       accept, ok;
  logic [1:0] in_status;
  logic [8:0] row9, col9;

  assign in_op  = op_t'(in_operation);
  assign accept = in_valid && in_ready;
  assign row9   = {1'b0, in_row_index};
  assign col9   = {1'b0, in_col_index};

  // The layer check wins over the index checks.
  always_comb begin
    in_status = ST_OK;
    if ({1'b0, in_layer} >= nl) begin
      in_status = ST_BAD_LAYER;
    end else begin
      unique case (in_op)
        OP_WR_A: begin
          if (row9 >= nr9 || col9 >= ni) in_status = ST_BAD_INDEX;
        end
        OP_WR_B: begin
          if (row9 >= no || col9 >= nr9) in_status = ST_BAD_INDEX;
        end
        OP_RD_GRAD: begin
          if (!in_matrix_sel) begin
            if (row9 >= nr9 || col9 >= ni) in_status = ST_BAD_INDEX;
          end else begin
            if (row9 >= no || col9 >= nr9) in_status = ST_BAD_INDEX;
          end
        end
        OP_FWD_X, OP_BWD_X, OP_BWD_GIN: begin
          if (col9 >= ni) in_status = ST_BAD_INDEX;
        end
        OP_FWD_OUT, OP_BWD_GOUT: begin
          if (row9 >= no) in_status = ST_BAD_INDEX;
        end
      endcase
    end
  end

  assign ok = (in_status == ST_OK);

  // Memory ports.
  logic                 clearing;
  logic [A_AW-1:0]      ai, a_acc;
  logic [B_AW-1:0]      bi, b_acc;
  logic                 wa_we, wa_re, wb_we, wb_re, ga_we, ga_re, gb_we, gb_re;
  logic                 tk_we, tk_re;
  logic [B_AW-1:0]      wb_waddr, gb_waddr, gb_raddr;
  logic [A_AW-1:0]      ga_waddr, ga_raddr;
  logic [31:0]          wb_wdata, ga_wdata, gb_wdata;
  logic [31:0]          wa_rd, wb_rd, ga_rd, gb_rd, tk_rd;
  logic signed [31:0]   wa_q, wb_q, ga_q, gb_q, tk_q;
  logic signed [31:0]   grad_new;

  assign clearing = (state_r == S_CLR);
  assign ai       = a_index(layer_r, 8'(r_r), col_r);
  assign bi       = b_index(layer_r, row_r, 8'(r_r));
  assign a_acc    = a_index(in_layer, in_row_index, in_col_index);
  assign b_acc    = b_index(in_layer, in_row_index, in_col_index);

  assign wa_q = wa_rd;
  assign wb_q = wb_rd;
  assign ga_q = ga_rd;
  assign gb_q = gb_rd;
  assign tk_q = tk_rd;

  // Gradient read-modify-write: old entry plus the scaled product.
  assign grad_new = sat32(64'((op_r == OP_BWD_GIN) ? ga_q : gb_q)
                          + 64'(sat32(floor16(ms_r))));

  assign wa_we = accept && ok && (in_op == OP_WR_A);
  assign wa_re = (state_r == S_RD) &&
                 (op_r == OP_FWD_X || op_r == OP_BWD_X || op_r == OP_BWD_GIN);

  assign wb_we    = (clearing && (32'(clr_cnt_r) < 32'(B_SIZE))) ||
                    (accept && ok && (in_op == OP_WR_B));
  assign wb_waddr = clearing ? B_AW'(clr_cnt_r) : b_acc;
  assign wb_wdata = clearing ? 32'd0 : in_value;
  assign wb_re    = (state_r == S_RD) && (op_r == OP_FWD_OUT || op_r == OP_BWD_GOUT);

  assign ga_we    = (clearing && (32'(clr_cnt_r) < 32'(A_SIZE))) ||
                    ((state_r == S_WB) && (op_r == OP_BWD_GIN));
  assign ga_waddr = clearing ? A_AW'(clr_cnt_r) : ai;
  assign ga_wdata = clearing ? 32'd0 : grad_new;
  assign ga_re    = ((state_r == S_RD) && (op_r == OP_BWD_GIN)) ||
                    (accept && ok && (in_op == OP_RD_GRAD) && !in_matrix_sel);
  assign ga_raddr = (state_r == S_RD) ? ai : a_acc;

  assign gb_we    = (clearing && (32'(clr_cnt_r) < 32'(B_SIZE))) ||
                    ((state_r == S_WB) && (op_r == OP_BWD_GOUT));
  assign gb_waddr = clearing ? B_AW'(clr_cnt_r) : bi;
  assign gb_wdata = clearing ? 32'd0 : grad_new;
  assign gb_re    = ((state_r == S_RD) && (op_r == OP_BWD_GOUT)) ||
                    (accept && ok && (in_op == OP_RD_GRAD) && in_matrix_sel);
  assign gb_raddr = (state_r == S_RD) ? bi : b_acc;

  assign tk_we = accept && ok && (in_op == OP_BWD_X);
  assign tk_re = accept && ok && (in_op == OP_BWD_GIN);

  lra_ram #(.WIDTH(32), .DEPTH(A_SIZE)) u_weight_a (
    .clk(clk), .we(wa_we), .waddr(a_acc), .wdata(in_value),
    .re(wa_re), .raddr(ai), .rdata(wa_rd)
  );

  lra_ram #(.WIDTH(32), .DEPTH(B_SIZE)) u_weight_b (
    .clk(clk), .we(wb_we), .waddr(wb_waddr), .wdata(wb_wdata),
    .re(wb_re), .raddr(bi), .rdata(wb_rd)
  );

  lra_ram #(.WIDTH(32), .DEPTH(A_SIZE)) u_grad_a (
    .clk(clk), .we(ga_we), .waddr(ga_waddr), .wdata(ga_wdata),
    .re(ga_re), .raddr(ga_raddr), .rdata(ga_rd)
  );

  lra_ram #(.WIDTH(32), .DEPTH(B_SIZE)) u_grad_b (
    .clk(clk), .we(gb_we), .waddr(gb_waddr), .wdata(gb_wdata),
    .re(gb_re), .raddr(gb_raddr), .rdata(gb_rd)
  );

  lra_ram #(.WIDTH(32), .DEPTH(MAX_IN_DIM)) u_token (
    .clk(clk), .we(tk_we), .waddr(T_AW'(in_col_index)), .wdata(in_value),
    .re(tk_re), .raddr(T_AW'(in_col_index)), .rdata(tk_rd)
  );

  // Accumulators: cleared on the first element of a pass, updated per rank entry.
  acc_cmd_t           acc_cmd;
  logic signed [31:0] proj_q, bproj_q;
  logic signed [63:0] m2_floor;

  assign m2_floor          = floor16(m2_r);
  assign acc_cmd.clr_proj  = accept && ok && (in_op == OP_FWD_X || in_op == OP_BWD_X) &&
                             (in_col_index == 8'd0);
  assign acc_cmd.clr_bproj = accept && ok && (in_op == OP_BWD_GOUT) && (in_row_index == 8'd0);
  assign acc_cmd.add_proj  = (state_r == S_SCL) && (op_r == OP_FWD_X || op_r == OP_BWD_X);
  assign acc_cmd.add_bproj = (state_r == S_SCL) && (op_r == OP_BWD_GOUT);

  lra_acc #(.MAX_RANK(MAX_RANK)) u_acc (
    .clk(clk), .rst_n(rst_n), .cmd(acc_cmd), .idx(r_r), .addend(m2_floor),
    .proj_q(proj_q), .bproj_q(bproj_q)
  );

  // Multiplier operand selection for the rank step.
  logic signed [31:0] ma1, mb1, ma2, mb2;
  logic signed [63:0] m1_nxt, m2_nxt, ms_nxt;
  logic signed [31:0] sc_in;
  logic signed [65:0] sc_prod;

  always_comb begin
    ma1 = val_r;
    mb1 = proj_q;
    ma2 = val_r;
    mb2 = wa_q;
    unique case (op_r)
      OP_FWD_OUT: begin
        ma2 = proj_q;
        mb2 = wb_q;
      end
      OP_BWD_GOUT: begin
        mb2 = wb_q;
      end
      OP_BWD_GIN: begin
        ma1 = bproj_q;
        mb1 = tk_q;
        ma2 = bproj_q;
      end
      default: ;
    endcase
  end

  assign m1_nxt  = ma1 * mb1;
  assign m2_nxt  = ma2 * mb2;
  // The scale multiply serves both the gradient term and the final delta.
  assign sc_in   = (state_r == S_FIN1) ? sat32(sum_r) : sat32(floor16(m1_r));
  assign sc_prod = $signed({sc_in[31], sc_in}) * $signed({1'b0, cfg_scale_r});
  assign ms_nxt  = sc_prod[63:0];

  logic r_last;
  assign r_last = (32'(r_r) + 32'd1 >= 32'(nr));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (32'(clr_cnt_r) == CLR_DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (!ok) begin
            state_nxt = S_DONE;
          end else begin
            unique case (in_op)
              OP_WR_A, OP_WR_B: state_nxt = S_DONE;
              OP_RD_GRAD: state_nxt = S_GRD;
              OP_FWD_X, OP_BWD_X, OP_BWD_GOUT: state_nxt = (nr == 5'd0) ? S_DONE : S_RD;
              OP_FWD_OUT, OP_BWD_GIN: state_nxt = (nr == 5'd0) ? S_FIN1 : S_RD;
            endcase
          end
        end
      end
      S_GRD: state_nxt = S_DONE;
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_SCL;
      S_SCL, S_WB: begin
        if (state_r == S_SCL && (op_r == OP_BWD_GOUT || op_r == OP_BWD_GIN)) begin
          state_nxt = S_WB;
        end else if (!r_last) begin
          state_nxt = S_RD;
        end else if (op_r == OP_FWD_OUT || op_r == OP_BWD_GIN) begin
          state_nxt = S_FIN1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIN1: state_nxt = (op_r == OP_BWD_GIN && skip_r) ? S_DONE : S_FIN2;
      S_FIN2: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + CLR_AW'(1);
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      layer_r  <= in_layer;
      row_r    <= in_row_index;
      col_r    <= in_col_index;
      val_r    <= in_value;
      msel_r   <= in_matrix_sel;
      skip_r   <= in_skip_result;
      status_r <= in_status;
      res_r    <= '0;
      r_r      <= '0;
      sum_r    <= '0;
    end
    if (state_r == S_GRD) res_r <= msel_r ? gb_q : ga_q;
    if (state_r == S_MUL) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
    end
    if (state_r == S_SCL) begin
      ms_r <= ms_nxt;
      if (op_r == OP_FWD_OUT || op_r == OP_BWD_GIN) sum_r <= sadd64(sum_r, m2_floor);
    end
    if (state_r == S_FIN1) ms_r <= ms_nxt;
    if ((state_r == S_SCL && op_r != OP_BWD_GOUT && op_r != OP_BWD_GIN) ||
        state_r == S_WB) begin
      if (!r_last) r_r <= r_r + RW'(1);
    end
    if (state_r == S_FIN2) res_r <= sat32(64'(val_r) + 64'(sat32(floor16(ms_r))));
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_status_r <= status_r;
      out_result_r <= res_r;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_result_r;

  // Any error status must carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_result_value == 32'sd0))
    else $error("error status with nonzero value");

  // The rank walk never addresses beyond the rank in use.
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (32'(r_r) < 32'(nr)))
    else $error("rank index out of range");

  // Gradient A is only written by the sweep or the writeback step.
  a_ga_write: assert property (@(posedge clk) disable iff (!rst_n)
    ga_we |-> (state_r == S_WB || state_r == S_CLR))
    else $error("unexpected gradient A write");

  // No item is taken while the memories are being cleared.
  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready)
    else $error("item accepted during clear sweep");

endmodule

`default_nettype wire
